// File: rtl/core/msr_pkg.sv
`timescale 1ns / 1ps

package msr_pkg;

	localparam int SEED_W = 31;
	localparam int N_W = 15;
	localparam int MULT_W = 15;
	localparam int PROD_W = SEED_W + MULT_W;
	localparam int DIV_STEPS = SEED_W;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
	localparam logic [SEED_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RED,
		ST_DIV,
		ST_OUT
	} msr_state_t;

	typedef struct packed {
		logic start;
		logic reduce;
		logic div_step;
		logic emit;
	} msr_cmd_t;

	typedef struct packed {
		logic out_free;
		logic seed_zero;
	} msr_status_t;

endpackage

// File: rtl/core/msr_if.sv
`timescale 1ns / 1ps

interface msr_req_if;
	logic valid;
	logic ready;
	logic [14:0] range_n;

	modport source (output valid, output range_n, input ready);
	modport sink (input valid, input range_n, output ready);
endinterface

interface msr_rsp_if;
	logic valid;
	logic ready;
	logic [14:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

// File: rtl/core/msr_ctrl.sv
`timescale 1ns / 1ps

module msr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  msr_pkg::msr_status_t status,
	output msr_pkg::msr_cmd_t    cmd,
	output msr_pkg::msr_state_t  state
);
	import msr_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	msr_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = ST_RED;
				end
			end
			ST_RED: begin
				cmd.reduce = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold the remainder until the output register frees up
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

// File: rtl/core/msr_dp.sv
`timescale 1ns / 1ps

module msr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msr_pkg::msr_cmd_t    cmd,
	input  logic [14:0]          range_n,
	output msr_pkg::msr_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [14:0]          random_value
);
	import msr_pkg::*;

	logic [SEED_W-1:0] seed_q;
	logic [N_W-1:0]    n_q;
	logic [PROD_W-1:0] prod_q;
	logic [SEED_W-1:0] quot_q;
	logic [N_W-1:0]    rem_q;
	logic              out_valid_q;
	logic [N_W-1:0]    out_data_q;

	logic [SEED_W-1:0] seed_op;
	logic [PROD_W-1:0] prod_d;
	logic [SEED_W:0]   red_sum;
	logic [SEED_W-1:0] seed_next;
	logic [N_W:0]      rem_sh;
	logic [N_W:0]      rem_sub;
	logic              rem_ge;

	// force a zero seed to one before the step
	assign seed_op = (seed_q == '0) ? SEED_RESET : seed_q;
	assign prod_d = PROD_W'(seed_op) * PROD_W'(LCG_MULT);

	// fold the high part back in: 2^31 is one modulo 2^31 - 1
	assign red_sum = {1'b0, prod_q[SEED_W-1:0]}
		+ (SEED_W + 1)'(prod_q[PROD_W-1:SEED_W]);
	assign seed_next = (red_sum >= {1'b0, LCG_MOD})
		? SEED_W'(red_sum - {1'b0, LCG_MOD})
		: red_sum[SEED_W-1:0];

	// restoring division step, one dividend bit a cycle
	assign rem_sh = {rem_q, quot_q[SEED_W-1]};
	assign rem_sub = rem_sh - {1'b0, n_q};
	assign rem_ge = (rem_sh >= {1'b0, n_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.reduce) begin
				seed_q <= seed_next;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q <= range_n;
			prod_q <= prod_d;
		end
		if (cmd.reduce) begin
			quot_q <= seed_next;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[SEED_W-2:0], 1'b0};
			rem_q <= rem_ge ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
		end
		if (cmd.emit) begin
			out_data_q <= (n_q == '0) ? '0 : rem_q;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.seed_zero = (seed_q == '0);
	assign out_valid = out_valid_q;
	assign random_value = out_data_q;

endmodule

// File: rtl/core/minimal_standard_random_mod_n_core.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload            | Transfer when
// --------+-----+--------------------+-----------------------
// req     | in  | range_n[14:0]      | req.valid && req.ready
// rsp     | out | random_value[14:0] | rsp.valid && rsp.ready
//
// Each request goes through these steps in order: capture range_n and multiply the seed
// by 16807, fold the product modulo 2^31 - 1, compute the bit-serial remainder of
// the 31-bit seed, then load the output register.
// Reset (arst_n low) sets the seed to 1 and empties the output register.
// A stalled response holds in the output register; a new request is taken
// meanwhile and waits in its last step until the register frees up.

module minimal_standard_random_mod_n_core (
	input logic clk,
	input logic arst_n,
	msr_req_if.sink   req,
	msr_rsp_if.source rsp
);
	import msr_pkg::*;

	msr_cmd_t    cmd;
	msr_status_t status;
	msr_state_t  state;
	logic        in_ready;

	// sequencer: walks capture, fold, divide and emit
	msr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	// seed register, multiplier, fold, divider and output register
	msr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.range_n      (req.range_n),
		.status       (status),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.random_value (rsp.random_value)
	);

	assign req.ready = in_ready;

	// a transfer in starts the work, so the next cycle takes no new request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous one in progress");

	// a response appears only out of the emit step
	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state == ST_OUT))
		else $error("response raised outside emit step");

	// the generator never reaches the zero seed from reset
	a_seed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!status.seed_zero)
		else $error("seed reached zero");

endmodule
